// File: hw/rtl/yrgb_pkg.sv
// ----------------------------------------------------------------------------
// yrgb_pkg
// Shared types, coefficients and helpers for the YUYV to RGB565 converter.
// ----------------------------------------------------------------------------
package yrgb_pkg;

  localparam int unsigned TermW = 19;

  typedef logic signed [TermW-1:0] term_t;

  localparam logic [7:0] LUMA_OFFSET  = 8'd16;
  localparam term_t      LUMA_GAIN    = 19'sd298;
  localparam term_t      RED_V_GAIN   = 19'sd409;
  localparam term_t      GREEN_U_GAIN = -19'sd100;
  localparam term_t      GREEN_V_GAIN = -19'sd208;
  localparam term_t      BLUE_U_GAIN  = 19'sd516;
  localparam term_t      ROUND_HALF   = 19'sd128;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } yuyv_t;

  typedef struct packed {
    logic [15:0] pixel_first;
    logic [15:0] pixel_second;
  } rgb_pair_t;

  typedef struct packed {
    term_t red;
    term_t green;
    term_t blue;
  } chroma_terms_t;

  // floor((s) / 256) saturated to 0..255, s already carries the rounding half
  function automatic logic [7:0] sat_channel(input term_t s);
    logic [7:0] res;
    if (s[TermW-1]) begin
      res = 8'd0;
    end else if (|s[TermW-2:16]) begin
      res = 8'hff;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/yrgb_in_if.sv
// ----------------------------------------------------------------------------
// yrgb_in_if
// Valid/ready channel carrying one packed YUYV macropixel word.
// ----------------------------------------------------------------------------
interface yrgb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_first;
  logic [7:0] chroma_blue;
  logic [7:0] luma_second;
  logic [7:0] chroma_red;

  modport source (
    output valid, luma_first, chroma_blue, luma_second, chroma_red,
    input  ready
  );

  modport sink (
    input  valid, luma_first, chroma_blue, luma_second, chroma_red,
    output ready
  );
endinterface

// File: hw/rtl/yrgb_out_if.sv
// ----------------------------------------------------------------------------
// yrgb_out_if
// Valid/ready channel carrying one word of two RGB565 pixels.
// ----------------------------------------------------------------------------
interface yrgb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_first;
  logic [15:0] pixel_second;

  modport source (
    output valid, pixel_first, pixel_second,
    input  ready
  );

  modport sink (
    input  valid, pixel_first, pixel_second,
    output ready
  );
endinterface

// File: hw/rtl/yrgb_chroma.sv
// ----------------------------------------------------------------------------
// yrgb_chroma
// Chroma contributions to red, green and blue from the shared U and V bytes.
// ----------------------------------------------------------------------------
module yrgb_chroma (
  input  logic [7:0]                   chroma_blue,
  input  logic [7:0]                   chroma_red,
  output yrgb_pkg::chroma_terms_t      terms
);

  logic [8:0]      u;
  logic [8:0]      v;
  yrgb_pkg::term_t u_ext;
  yrgb_pkg::term_t v_ext;

  // byte minus 128 in two's complement
  assign u = {~chroma_blue[7], ~chroma_blue[7], chroma_blue[6:0]};
  assign v = {~chroma_red[7], ~chroma_red[7], chroma_red[6:0]};

  assign u_ext = {{(yrgb_pkg::TermW-9){u[8]}}, u};
  assign v_ext = {{(yrgb_pkg::TermW-9){v[8]}}, v};

  assign terms.red   = v_ext * yrgb_pkg::RED_V_GAIN;
  assign terms.green = u_ext * yrgb_pkg::GREEN_U_GAIN + v_ext * yrgb_pkg::GREEN_V_GAIN;
  assign terms.blue  = u_ext * yrgb_pkg::BLUE_U_GAIN;

endmodule

// File: hw/rtl/yrgb_pixel.sv
// ----------------------------------------------------------------------------
// yrgb_pixel
// One pixel: luma scaling, channel sums, saturation and RGB565 packing.
// ----------------------------------------------------------------------------
module yrgb_pixel (
  input  logic [7:0]                   luma,
  input  yrgb_pkg::chroma_terms_t      terms,
  output logic [15:0]                  pixel
);

  logic [7:0]      y;
  yrgb_pkg::term_t y_term;
  yrgb_pkg::term_t sum_r;
  yrgb_pkg::term_t sum_g;
  yrgb_pkg::term_t sum_b;
  logic [7:0]      r;
  logic [7:0]      g;
  logic [7:0]      b;

  // black level clamp
  assign y = (luma < yrgb_pkg::LUMA_OFFSET) ? 8'd0 : (luma - yrgb_pkg::LUMA_OFFSET);

  assign y_term = $signed({{(yrgb_pkg::TermW-8){1'b0}}, y}) * yrgb_pkg::LUMA_GAIN;

  assign sum_r = y_term + terms.red   + yrgb_pkg::ROUND_HALF;
  assign sum_g = y_term + terms.green + yrgb_pkg::ROUND_HALF;
  assign sum_b = y_term + terms.blue  + yrgb_pkg::ROUND_HALF;

  assign r = yrgb_pkg::sat_channel(sum_r);
  assign g = yrgb_pkg::sat_channel(sum_g);
  assign b = yrgb_pkg::sat_channel(sum_b);

  assign pixel = {r[7:3], g[7:2], b[7:3]};

endmodule

// File: hw/rtl/yuyv_to_rgb565_converter.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb565_converter
// Converts packed YUYV macropixels into pairs of RGB565 pixels (BT.601).
// ----------------------------------------------------------------------------
// One YUYV word is taken every clock unless the output stalls, and its two
// RGB565 pixels reach the output through the input and result registers: the
// word is captured in an input register, the constant multiplies, channel
// sums and saturation run in one pass of logic, and the packed pair lands in
// the result register once it is free. Throughput is one word per clock as
// long as the sink takes results; a stalled result holds its register and one
// more word may wait in the input register before ready drops.
module yuyv_to_rgb565_converter (
  input  logic              clk,
  input  logic              rst,
  yrgb_in_if.sink           yuyv,
  yrgb_out_if.source        rgb
);

  yrgb_pkg::yuyv_t          in_reg;
  logic                     in_valid;
  yrgb_pkg::rgb_pair_t      out_reg;
  logic                     out_valid;
  yrgb_pkg::rgb_pair_t      out_next;
  yrgb_pkg::chroma_terms_t  terms;
  logic                     out_load;
  logic                     in_load;

  assign out_load   = !out_valid || rgb.ready;
  assign yuyv.ready = !in_valid || out_load;
  assign in_load    = yuyv.valid && yuyv.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (yuyv.ready) begin
      in_valid <= yuyv.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_reg.luma_first  <= yuyv.luma_first;
      in_reg.chroma_blue <= yuyv.chroma_blue;
      in_reg.luma_second <= yuyv.luma_second;
      in_reg.chroma_red  <= yuyv.chroma_red;
    end
  end

  yrgb_chroma u_chroma (
    .chroma_blue (in_reg.chroma_blue),
    .chroma_red  (in_reg.chroma_red),
    .terms       (terms)
  );

  yrgb_pixel u_pixel_first (
    .luma  (in_reg.luma_first),
    .terms (terms),
    .pixel (out_next.pixel_first)
  );

  yrgb_pixel u_pixel_second (
    .luma  (in_reg.luma_second),
    .terms (terms),
    .pixel (out_next.pixel_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      out_reg <= out_next;
    end
  end

  assign rgb.valid        = out_valid;
  assign rgb.pixel_first  = out_reg.pixel_first;
  assign rgb.pixel_second = out_reg.pixel_second;

endmodule

// File: hw/rtl/yrgb_checker.sv
// ----------------------------------------------------------------------------
// yrgb_checker
// Port-level assertions for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module yrgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] pixel_first,
  input logic [15:0] pixel_second
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // with the result register empty the input side must take a word
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  // a waiting result keeps its pixels
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_first)
      && $stable(pixel_second))
    else $error("stalled result word changed");

  // a word offered while the sink is taking results is never refused
  a_flow_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule

bind yuyv_to_rgb565_converter yrgb_checker u_yrgb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (yuyv.ready),
  .out_valid    (rgb.valid),
  .out_ready    (rgb.ready),
  .pixel_first  (rgb.pixel_first),
  .pixel_second (rgb.pixel_second)
);
